### hdl/gdt_pkg.sv
package gdt_pkg;

   localparam int ValueWidth    = 63;
   localparam int NumDigits     = 19;
   localparam int DigitWidth    = 4;
   localparam int BcdWidth      = NumDigits * DigitWidth;
   localparam int CharWidth     = 6;
   localparam int PosWidth      = 5;
   localparam int StepsPerStage = 4;

   localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
   localparam logic [CharWidth-1:0] AsciiComma = 6'd44;

   // Partial double-dabble state: decimal digits built so far and the
   // binary bits still to be shifted in, most significant bit on top.
   typedef struct packed {
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] bin;
   } work_type;

   // Number of significant digits, at least one.
   function automatic logic [PosWidth-1:0] digit_count(input logic [BcdWidth-1:0] bcd);
      logic [PosWidth-1:0] n;
      n = PosWidth'(1);
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd[i*DigitWidth +: DigitWidth] != '0) begin
            n = PosWidth'(i + 1);
         end
      end
      return n;
   endfunction

   // Width of the leading group: digit count mod 3, with 3 in place of 0.
   function automatic logic [1:0] lead_group(input logic [PosWidth-1:0] n);
      logic [1:0] g;
      case (n)
         5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19: g = 2'd1;
         5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17:        g = 2'd2;
         default:                                       g = 2'd3;
      endcase
      return g;
   endfunction

endpackage

### hdl/gdt_dabble_stage.sv
module gdt_dabble_stage #(
   parameter int NUM_STEPS = gdt_pkg::StepsPerStage
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gdt_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output gdt_pkg::work_type out_work
);

   logic              valid_ff;
   gdt_pkg::work_type work_ff;
   gdt_pkg::work_type work_in;

   // Each step: add 3 to every digit of 5 or more, then shift one bit in.
   always_comb begin
      work_in = in_work;
      for (int k = 0; k < NUM_STEPS; k++) begin
         for (int d = 0; d < gdt_pkg::NumDigits; d++) begin
            if (work_in.bcd[d*gdt_pkg::DigitWidth +: gdt_pkg::DigitWidth] >= 4'd5) begin
               work_in.bcd[d*gdt_pkg::DigitWidth +: gdt_pkg::DigitWidth] =
                  work_in.bcd[d*gdt_pkg::DigitWidth +: gdt_pkg::DigitWidth] + 4'd3;
            end
         end
         work_in.bcd = {work_in.bcd[gdt_pkg::BcdWidth-2:0],
                        work_in.bin[gdt_pkg::ValueWidth-1]};
         work_in.bin = {work_in.bin[gdt_pkg::ValueWidth-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

### hdl/gdt_serializer.sv
module gdt_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [gdt_pkg::BcdWidth-1:0]      in_bcd,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [gdt_pkg::CharWidth-1:0]     out_char,
   output logic                              out_last
);

   logic                                busy_ff, busy_in;
   logic [gdt_pkg::DigitWidth-1:0]      digits_ff [gdt_pkg::NumDigits];
   logic [gdt_pkg::PosWidth-1:0]        pos_ff, pos_in;
   logic [1:0]                          grp_ff, grp_in;
   logic                                comma_ff, comma_in;
   logic                                out_valid_ff, out_valid_in;
   logic [gdt_pkg::CharWidth-1:0]       out_char_ff, out_char_in;
   logic                                out_last_ff, out_last_in;
   logic [gdt_pkg::PosWidth-1:0]        ndig;
   logic                                emit, finish, load;

   assign emit     = busy_ff && (!out_valid_ff || out_ready);
   assign finish   = emit && !comma_ff && (pos_ff == '0);
   assign in_ready = !busy_ff || finish;
   assign load     = in_valid && in_ready;
   assign ndig     = gdt_pkg::digit_count(in_bcd);

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      grp_in       = grp_ff;
      comma_in     = comma_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (comma_ff) begin
            out_char_in = gdt_pkg::AsciiComma;
            out_last_in = 1'b0;
            comma_in    = 1'b0;
         end else begin
            out_char_in = gdt_pkg::AsciiZero + {2'b00, digits_ff[pos_ff]};
            out_last_in = (pos_ff == '0);
            if (pos_ff != '0) begin
               pos_in = pos_ff - 1'b1;
               if (grp_ff == 2'd1) begin
                  comma_in = 1'b1;
                  grp_in   = 2'd3;
               end else begin
                  grp_in = grp_ff - 1'b1;
               end
            end else begin
               busy_in = 1'b0;
            end
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         busy_in  = 1'b1;
         pos_in   = ndig - 1'b1;
         grp_in   = gdt_pkg::lead_group(ndig);
         comma_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         comma_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         comma_ff     <= comma_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      grp_ff      <= grp_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (load) begin
         for (int i = 0; i < gdt_pkg::NumDigits; i++) begin
            digits_ff[i] <= in_bcd[i*gdt_pkg::DigitWidth +: gdt_pkg::DigitWidth];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule

### hdl/integer_to_grouped_decimal_text_top.sv
// Grouped decimal text generator.
//
// Request channel (req_): one 63-bit unsigned integer per request in
// req_tdata[62:0]; bit 63 is ignored.
// Response channel (rsp_): one ASCII character per transfer, most
// significant digit first, with a comma between groups of three digits.
// rsp_tlast marks the final character of each number. Zero gives "0".
//
// Latency: the binary-to-BCD conversion runs as a shift-and-add-3 pipeline
// of ceil(63 / STEPS_PER_STAGE) register stages (16 at the default),
// followed by the character sequencer, which loads each number, and one
// output register that drives the response channel.
// Throughput: the output register emits one character per cycle while
// rsp_tready is high; a number of n digits gives n + (n-1)/3 characters
// (1 to 25). Requests enter the pipeline every cycle while it has room,
// and the sequencer loads the next number in the cycle it sends the
// previous number's last character.
// Reset (synchronous, active high) empties every stage and the output.
// When the receiver holds rsp_tready low, the output holds, the pipeline
// fills up and req_tready drops; nothing is lost or repeated.
module integer_to_grouped_decimal_text_top #(
   parameter int STEPS_PER_STAGE = gdt_pkg::StepsPerStage
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] value, [63] pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] character, [7:6] zero
   output logic        rsp_tlast
);

   localparam int NumStages =
      (gdt_pkg::ValueWidth + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   logic              stage_valid [NumStages+1];
   logic              stage_ready [NumStages+1];
   gdt_pkg::work_type stage_work  [NumStages+1];
   logic [gdt_pkg::CharWidth-1:0] rsp_char;

   // Start with no digits and the whole value waiting to shift in.
   assign stage_valid[0]    = req_tvalid;
   assign req_tready        = stage_ready[0];
   assign stage_work[0].bcd = '0;
   assign stage_work[0].bin = req_tdata[gdt_pkg::ValueWidth-1:0];

   // Conversion pipeline: the last stage takes whatever steps remain.
   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      localparam int Steps = (s == NumStages - 1) ?
         gdt_pkg::ValueWidth - (NumStages - 1) * STEPS_PER_STAGE : STEPS_PER_STAGE;
      gdt_dabble_stage #(
         .NUM_STEPS (Steps)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_work   (stage_work[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_work  (stage_work[s+1])
      );
   end

   // Walk the digits out as characters, inserting group commas.
   gdt_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NumStages]),
      .in_ready  (stage_ready[NumStages]),
      .in_bcd    (stage_work[NumStages].bcd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};

endmodule
